FILE: hw/rtl/ubp_pkg.sv
// Package with the sizes, command codes, shared types and helpers of the byte packetizer.
package ubp_pkg;

    localparam int ROW_BYTES = 20;
    localparam int ROWS      = 16;

    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int USED_W = $clog2(ROWS + 1);
    localparam int LEN_W  = $clog2(ROW_BYTES + 1);
    localparam int ADDR_W = $clog2(ROWS * ROW_BYTES);
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int PLEN_W = 5;
    localparam int CNT_W  = 16;

    localparam logic [CMD_W-1:0] CMD_RX      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TX_DONE = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic take;
        logic exec;
        logic rd;
        logic emit;
    } ubp_cmd_t;

    typedef struct packed {
        logic pop_run;
        logic run_last;
    } ubp_stat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_of_run;
        logic [PLEN_W-1:0] popped_length;
        logic              send_request;
        logic              ring_full;
        logic              ring_empty;
        logic              receiving;
        logic              byte_dropped;
        logic [CNT_W-1:0]  full_events;
        logic [CNT_W-1:0]  empty_events;
    } ubp_result_t;

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] n;
        n = (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = (c == CNT_MAX) ? c : c + 1'b1;
        return n;
    endfunction

endpackage

FILE: hw/rtl/ubp_ifs.sv
// Request and result channel interfaces of the byte packetizer.
interface ubp_in_if
    import ubp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink (input valid, command, rx_byte, output ready);
endinterface

interface ubp_out_if
    import ubp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic [PLEN_W-1:0] popped_length;
    logic              send_request;
    logic              ring_full;
    logic              ring_empty;
    logic              receiving;
    logic              byte_dropped;
    logic [CNT_W-1:0]  full_events;
    logic [CNT_W-1:0]  empty_events;

    modport source (output valid, out_byte, byte_valid, last_of_run, popped_length,
                    send_request, ring_full, ring_empty, receiving, byte_dropped,
                    full_events, empty_events, input ready);
    modport sink (input valid, out_byte, byte_valid, last_of_run, popped_length,
                  send_request, ring_full, ring_empty, receiving, byte_dropped,
                  full_events, empty_events, output ready);
endinterface

FILE: hw/rtl/ubp_ctrl.sv
// Controller state machine that sequences requests, row pops and the result register.
module ubp_ctrl
    import ubp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    input  ubp_stat_t stat,
    output ubp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP_RD = 2'd1;
    localparam logic [1:0] S_POP_WR = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       hold_vld_reg, hold_vld_next;
    logic       out_vld_reg, out_vld_next;
    logic       out_free;

    assign out_free  = !out_vld_reg || out_ready;
    assign in_ready  = !hold_vld_reg;
    assign out_valid = out_vld_reg;

    always_comb
    begin
        state_next    = state_reg;
        hold_vld_next = hold_vld_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        cmd           = '0;
        cmd.take      = in_valid && !hold_vld_reg;
        if (cmd.take)
        begin
            hold_vld_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (hold_vld_reg && out_free)
                begin
                    cmd.exec      = 1'b1;
                    hold_vld_next = 1'b0;
                    if (stat.pop_run)
                    begin
                        state_next = S_POP_RD;
                    end
                    else
                    begin
                        out_vld_next = 1'b1;
                    end
                end
            end
            S_POP_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                if (out_free)
                begin
                    cmd.emit     = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = stat.run_last ? S_IDLE : S_POP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

FILE: hw/rtl/ubp_dpath.sv
// Datapath with the ring pointers, the row memories, the event counters and the result register.
module ubp_dpath
    import ubp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [CMD_W-1:0]  in_command,
    input  logic [BYTE_W-1:0] in_rx_byte,
    input  ubp_cmd_t          cmd,
    output ubp_stat_t         stat,
    output ubp_result_t       result
);

    localparam logic [ADDR_W-1:0] RB_A   = ADDR_W'(ROW_BYTES);
    localparam logic [LEN_W-1:0]  RB_L   = LEN_W'(ROW_BYTES);
    localparam logic [USED_W-1:0] ROWS_U = USED_W'(ROWS);

    logic [BYTE_W-1:0] row_mem [ROWS*ROW_BYTES];
    logic [LEN_W-1:0]  len_mem [ROWS];

    logic              recv_en_reg;
    logic [CMD_W-1:0]  hold_cmd_reg;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic [ROW_W-1:0]  write_row_reg, write_row_next;
    logic [ROW_W-1:0]  read_row_reg, read_row_next;
    logic [USED_W-1:0] rows_used_reg, rows_used_next;
    logic [LEN_W-1:0]  open_len_reg, open_len_next;
    logic              rx_run_reg, rx_run_next;
    logic              tx_busy_reg, tx_busy_next;
    logic [CNT_W-1:0]  full_cnt_reg, full_cnt_next;
    logic [CNT_W-1:0]  empty_cnt_reg, empty_cnt_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] rdata_reg;
    ubp_result_t       result_reg;

    logic              mem_we;
    logic              len_we;
    logic              closing;
    logic              send;
    logic              dropped;
    logic [LEN_W-1:0]  close_len;
    logic [ADDR_W-1:0] waddr;

    assign stat.pop_run  = (hold_cmd_reg == CMD_POP) && (rows_used_reg != '0);
    assign stat.run_last = (cnt_reg + LEN_W'(1)) == len_reg;
    assign waddr         = ADDR_W'(write_row_reg) * RB_A + ADDR_W'(open_len_reg);
    assign result        = result_reg;

    always_comb
    begin
        write_row_next = write_row_reg;
        read_row_next  = read_row_reg;
        rows_used_next = rows_used_reg;
        open_len_next  = open_len_reg;
        rx_run_next    = rx_run_reg;
        tx_busy_next   = tx_busy_reg;
        full_cnt_next  = full_cnt_reg;
        empty_cnt_next = empty_cnt_reg;
        mem_we         = 1'b0;
        len_we         = 1'b0;
        closing        = 1'b0;
        send           = 1'b0;
        dropped        = 1'b0;
        case (hold_cmd_reg)
            CMD_RX:
            begin
                if (!recv_en_reg || !rx_run_reg || open_len_reg >= RB_L)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    mem_we        = 1'b1;
                    open_len_next = open_len_reg + 1'b1;
                    closing       = (open_len_next == RB_L);
                end
            end
            CMD_TIMEOUT:
            begin
                closing = (open_len_reg != '0);
            end
            CMD_POP:
            begin
                if (rows_used_reg != '0)
                begin
                    read_row_next  = row_inc(read_row_reg);
                    rows_used_next = rows_used_reg - 1'b1;
                    if (rows_used_next == '0)
                    begin
                        empty_cnt_next = sat_inc(empty_cnt_reg);
                        if (!rx_run_reg)
                        begin
                            write_row_next = '0;
                            read_row_next  = '0;
                            open_len_next  = '0;
                            tx_busy_next   = 1'b0;
                            rx_run_next    = 1'b1;
                        end
                    end
                end
            end
            CMD_TX_DONE:
            begin
                tx_busy_next = 1'b0;
            end
            default:
            begin
            end
        endcase
        close_len = open_len_next;
        if (closing && rows_used_reg < ROWS_U)
        begin
            len_we         = 1'b1;
            write_row_next = row_inc(write_row_reg);
            rows_used_next = rows_used_reg + 1'b1;
            open_len_next  = '0;
            if (rows_used_next == ROWS_U)
            begin
                full_cnt_next = sat_inc(full_cnt_reg);
                rx_run_next   = 1'b0;
            end
            if (!tx_busy_reg)
            begin
                tx_busy_next = 1'b1;
                send         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_en_reg   <= 1'b1;
            write_row_reg <= '0;
            read_row_reg  <= '0;
            rows_used_reg <= '0;
            open_len_reg  <= '0;
            rx_run_reg    <= 1'b1;
            tx_busy_reg   <= 1'b0;
            full_cnt_reg  <= '0;
            empty_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                recv_en_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                write_row_reg <= write_row_next;
                read_row_reg  <= read_row_next;
                rows_used_reg <= rows_used_next;
                open_len_reg  <= open_len_next;
                rx_run_reg    <= rx_run_next;
                tx_busy_reg   <= tx_busy_next;
                full_cnt_reg  <= full_cnt_next;
                empty_cnt_reg <= empty_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            row_mem[waddr] <= hold_byte_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= row_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && len_we)
        begin
            len_mem[write_row_reg] <= close_len;
        end
        if (cmd.exec && stat.pop_run)
        begin
            len_reg <= len_mem[read_row_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            hold_cmd_reg  <= in_command;
            hold_byte_reg <= in_rx_byte;
        end
        if (cmd.exec && stat.pop_run)
        begin
            addr_reg <= ADDR_W'(read_row_reg) * RB_A;
            cnt_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            addr_reg <= addr_reg + 1'b1;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.exec && !stat.pop_run)
        begin
            result_reg.out_byte      <= '0;
            result_reg.byte_valid    <= 1'b0;
            result_reg.last_of_run   <= 1'b1;
            result_reg.popped_length <= '0;
            result_reg.send_request  <= send;
            result_reg.ring_full     <= (rows_used_next >= ROWS_U);
            result_reg.ring_empty    <= (rows_used_next == '0);
            result_reg.receiving     <= rx_run_next;
            result_reg.byte_dropped  <= dropped;
            result_reg.full_events   <= full_cnt_next;
            result_reg.empty_events  <= empty_cnt_next;
        end
        else if (cmd.emit)
        begin
            result_reg.out_byte      <= rdata_reg;
            result_reg.byte_valid    <= 1'b1;
            result_reg.last_of_run   <= stat.run_last;
            result_reg.popped_length <= PLEN_W'(len_reg);
            result_reg.send_request  <= 1'b0;
            result_reg.ring_full     <= (rows_used_reg >= ROWS_U);
            result_reg.ring_empty    <= (rows_used_reg == '0);
            result_reg.receiving     <= rx_run_reg;
            result_reg.byte_dropped  <= 1'b0;
            result_reg.full_events   <= full_cnt_reg;
            result_reg.empty_events  <= empty_cnt_reg;
        end
    end

endmodule

FILE: hw/rtl/uart_byte_packetizer_fifo.sv
// Top level of the UART byte packetizer with its ring of closed rows.
//
//   channel  | direction | payload
//   in_ch    | sink      | command, rx_byte
//   out_ch   | source    | out_byte, byte_valid, last_of_run, popped_length, status, counters
//   cfg      | write     | cfg_wdata is receive_enable
//
// A request that is not a pop of a stored row yields exactly one result.
// A pop of a row of L bytes yields L results: each byte is one read of the row memory
// and one load of the result register.
// The next request is taken into a holding register while a result still waits.
// Reset clears the pointers, counters and busy flags and sets receiving and receive enable;
// the row memories are not cleared. A stalled result channel holds the sequencer until the result register is free.
module uart_byte_packetizer_fifo
    import ubp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    ubp_in_if.sink    in_ch,
    ubp_out_if.source out_ch
);

    ubp_cmd_t    cmd;
    ubp_stat_t   stat;
    ubp_result_t result;

    ubp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ubp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_command (in_ch.command),
        .in_rx_byte (in_ch.rx_byte),
        .cmd        (cmd),
        .stat       (stat),
        .result     (result)
    );

    assign out_ch.out_byte      = result.out_byte;
    assign out_ch.byte_valid    = result.byte_valid;
    assign out_ch.last_of_run   = result.last_of_run;
    assign out_ch.popped_length = result.popped_length;
    assign out_ch.send_request  = result.send_request;
    assign out_ch.ring_full     = result.ring_full;
    assign out_ch.ring_empty    = result.ring_empty;
    assign out_ch.receiving     = result.receiving;
    assign out_ch.byte_dropped  = result.byte_dropped;
    assign out_ch.full_events   = result.full_events;
    assign out_ch.empty_events  = result.empty_events;

    a_full_stops_rx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ring_full |-> !out_ch.receiving && !out_ch.ring_empty)
        else $error("full ring reported while receiving or empty");

    a_pop_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.byte_valid |-> out_ch.popped_length != '0)
        else $error("row byte without a row length");

    a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.byte_valid |-> !out_ch.send_request && !out_ch.byte_dropped)
        else $error("row byte carries request flags");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.byte_valid |-> out_ch.last_of_run)
        else $error("single result without last marker");

endmodule
